>>> src/quad_corner_order_aspect_check_assert.svh
// assertion macros for the quad corner order and aspect check block
// depends on nothing; included by qcoac_sqrt and the top level
`ifndef QUAD_CORNER_ORDER_ASPECT_CHECK_ASSERT_SVH
`define QUAD_CORNER_ORDER_ASPECT_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
`define QC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QC_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QC_ASSERT(label, clk, rst_n, prop, msg)
`define QC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> src/qcoac_pkg.sv
// shared constants and types for the quad corner order and aspect check block
// depends on nothing
package qcoac_pkg;
  localparam int unsigned CoordBits    = 12;
  localparam int unsigned LenFracBits  = 4;
  localparam int unsigned RatioFrac    = 12;
  localparam int unsigned RegBits      = 16;
  localparam logic [15:0] TargetReset  = 16'd7282;
  localparam logic [15:0] TolReset     = 16'd410;

  typedef enum logic [0:0] {
    REG_TARGET = 1'b0,
    REG_TOL    = 1'b1
  } reg_idx_e;

  // stage handshake between pipeline stages
  typedef struct packed {
    logic valid;
    logic stall;
  } stage_ctl_t;
endpackage

>>> src/qcoac_sqrt.sv
// pipelined floored square root, one result bit per stage
// depends on qcoac_pkg and the assertion macro header
`include "quad_corner_order_aspect_check_assert.svh"
module qcoac_sqrt #(
  parameter int unsigned InBits  = 2 * (qcoac_pkg::CoordBits + 1 + qcoac_pkg::LenFracBits),
  parameter int unsigned OutBits = (InBits + 1) / 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [InBits-1:0]  val_i,
  output logic [OutBits-1:0] root_o
);
  localparam int unsigned PadBits = 2 * OutBits;
  localparam int unsigned RemBits = OutBits + 2;

  logic [PadBits-1:0] rad_q  [OutBits+1];
  logic [OutBits-1:0] root_q [OutBits+1];
  logic [RemBits-1:0] rem_q  [OutBits+1];

  // stage zero is the padded input
  always_comb begin
    rad_q[0]  = PadBits'(val_i);
    root_q[0] = '0;
    rem_q[0]  = '0;
  end

  // restoring root, two radicand bits per stage
  for (genvar s = 0; s < OutBits; s++) begin : g_stage
    logic [RemBits-1:0] trial;
    logic [RemBits-1:0] rem_sh;
    logic [RemBits-1:0] sub;
    always_comb begin
      rem_sh = {rem_q[s][RemBits-3:0], rad_q[s][PadBits-1 -: 2]};
      trial  = {root_q[s], 2'b01};
      sub    = rem_sh - trial;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1] <= rad_q[s] << 2;
        if (rem_sh >= trial) begin
          rem_q[s+1]  <= sub;
          root_q[s+1] <= {root_q[s][OutBits-2:0], 1'b1};
        end else begin
          rem_q[s+1]  <= rem_sh;
          root_q[s+1] <= {root_q[s][OutBits-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[OutBits];
  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule

>>> src/quad_corner_order_aspect_check.sv
// top level of the quad corner order and aspect check block
// depends on qcoac_pkg, qcoac_sqrt and the assertion macro header
//
// channel   direction  handshake
// in        input      in_valid_i / in_stall_o, pt0..pt3 x and y
// out       output     out_valid_o / out_stall_i, four corners and plausible
// cfg       input      cfg_we_i, cfg_idx_i, cfg_data_i
//
// one transaction per cycle while out_stall_i is low; stages: corner select,
// squared lengths, one-bit-per-stage square root, sums, products, compare
// reset clears the valid bits and loads the register defaults
// a stall at the output freezes the whole pipeline; nothing is lost
`include "quad_corner_order_aspect_check_assert.svh"
module quad_corner_order_aspect_check #(
  parameter int unsigned COORD_BITS    = qcoac_pkg::CoordBits,
  parameter int unsigned LEN_FRAC_BITS = qcoac_pkg::LenFracBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] pt0_x_i,
  input  logic [COORD_BITS-1:0] pt0_y_i,
  input  logic [COORD_BITS-1:0] pt1_x_i,
  input  logic [COORD_BITS-1:0] pt1_y_i,
  input  logic [COORD_BITS-1:0] pt2_x_i,
  input  logic [COORD_BITS-1:0] pt2_y_i,
  input  logic [COORD_BITS-1:0] pt3_x_i,
  input  logic [COORD_BITS-1:0] pt3_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] top_left_x_o,
  output logic [COORD_BITS-1:0] top_left_y_o,
  output logic [COORD_BITS-1:0] top_right_x_o,
  output logic [COORD_BITS-1:0] top_right_y_o,
  output logic [COORD_BITS-1:0] bottom_right_x_o,
  output logic [COORD_BITS-1:0] bottom_right_y_o,
  output logic [COORD_BITS-1:0] bottom_left_x_o,
  output logic [COORD_BITS-1:0] bottom_left_y_o,
  output logic                  plausible_o
);
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SqIn  = 2 * (CB + 1 + LEN_FRAC_BITS);
  localparam int unsigned LenB  = (SqIn + 1) / 2;
  localparam int unsigned RootD = LenB;
  localparam int unsigned H2B   = LenB + 1;
  localparam int unsigned W4B   = H2B + qcoac_pkg::RatioFrac;
  localparam int unsigned PB    = H2B + 16;
  localparam int unsigned DB    = (W4B > PB ? W4B : PB) + 1;
  localparam int unsigned Depth = 2 + RootD + 3;

  typedef logic [CB-1:0] crd_t;
  typedef struct packed {
    crd_t tlx, tly, trx, try_, brx, bry, blx, bly;
  } corners_t;

  qcoac_pkg::stage_ctl_t ctl;
  logic en;
  logic [Depth-1:0] vld_q;

  assign ctl.stall  = out_stall_i;
  assign en         = !out_stall_i;
  assign ctl.valid  = vld_q[Depth-1];
  assign in_stall_o = ctl.stall;
  assign out_valid_o = ctl.valid;

  // configuration registers
  logic [15:0] target_q, tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= qcoac_pkg::TargetReset;
      tol_q    <= qcoac_pkg::TolReset;
    end else if (cfg_we_i) begin
      unique case (qcoac_pkg::reg_idx_e'(cfg_idx_i))
        qcoac_pkg::REG_TARGET: target_q <= cfg_data_i;
        qcoac_pkg::REG_TOL:    tol_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // stage 1: corner selection
  crd_t xs [4];
  crd_t ys [4];
  assign xs[0] = pt0_x_i; assign ys[0] = pt0_y_i;
  assign xs[1] = pt1_x_i; assign ys[1] = pt1_y_i;
  assign xs[2] = pt2_x_i; assign ys[2] = pt2_y_i;
  assign xs[3] = pt3_x_i; assign ys[3] = pt3_y_i;

  corners_t c1_d, c1_q;
  always_comb begin
    logic [CB:0] s [4];
    logic signed [CB+1:0] d [4];
    logic [1:0] tl, br, tr, bl;
    for (int i = 0; i < 4; i++) begin
      s[i] = {1'b0, xs[i]} + {1'b0, ys[i]};
      d[i] = $signed({2'b00, ys[i]}) - $signed({2'b00, xs[i]});
    end
    tl = 2'd0; br = 2'd0; tr = 2'd0; bl = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (s[i] <  s[tl]) tl = 2'(i);
      if (s[i] >= s[br]) br = 2'(i);
      if (d[i] <  d[tr]) tr = 2'(i);
      if (d[i] >= d[bl]) bl = 2'(i);
    end
    c1_d.tlx = xs[tl]; c1_d.tly = ys[tl];
    c1_d.trx = xs[tr]; c1_d.try_ = ys[tr];
    c1_d.brx = xs[br]; c1_d.bry = ys[br];
    c1_d.blx = xs[bl]; c1_d.bly = ys[bl];
  end
  always_ff @(posedge clk_i) if (en) c1_q <= c1_d;

  // stage 2: squared side lengths, scaled by the fraction bits
  function automatic logic [SqIn-1:0] sq_len(crd_t ax, crd_t ay, crd_t bx, crd_t by);
    crd_t dx, dy;
    logic [2*CB-1:0] dx2, dy2;
    logic [2*CB:0] acc;
    dx  = ax > bx ? ax - bx : bx - ax;
    dy  = ay > by ? ay - by : by - ay;
    dx2 = (2*CB)'(dx) * (2*CB)'(dx);
    dy2 = (2*CB)'(dy) * (2*CB)'(dy);
    acc = {1'b0, dx2} + {1'b0, dy2};
    return SqIn'(acc) << (2 * LEN_FRAC_BITS);
  endfunction

  logic [SqIn-1:0] sq_q [4];
  corners_t c2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q     <= c1_q;
      sq_q[0] <= sq_len(c1_q.tlx, c1_q.tly, c1_q.trx, c1_q.try_);
      sq_q[1] <= sq_len(c1_q.blx, c1_q.bly, c1_q.brx, c1_q.bry);
      sq_q[2] <= sq_len(c1_q.tlx, c1_q.tly, c1_q.blx, c1_q.bly);
      sq_q[3] <= sq_len(c1_q.trx, c1_q.try_, c1_q.brx, c1_q.bry);
    end
  end

  // square root stages, corners ride alongside
  logic [LenB-1:0] len [4];
  for (genvar k = 0; k < 4; k++) begin : g_root
    qcoac_sqrt #(.InBits(SqIn), .OutBits(LenB)) u_sqrt (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .val_i (sq_q[k]), .root_o (len[k])
    );
  end
  corners_t cr_q [RootD];
  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q[0] <= c2_q;
      for (int i = 1; i < RootD; i++) cr_q[i] <= cr_q[i-1];
    end
  end

  // stage a: sums
  logic [H2B-1:0] w2_q, h2_q;
  corners_t ca_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      w2_q <= {1'b0, len[0]} + {1'b0, len[1]};
      h2_q <= {1'b0, len[2]} + {1'b0, len[3]};
      ca_q <= cr_q[RootD-1];
    end
  end

  // stage b: products
  logic [DB-1:0] lhsa_q, lhsb_q, lim_q;
  logic hpos_q;
  corners_t cb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      lhsa_q <= DB'(w2_q) << qcoac_pkg::RatioFrac;
      lhsb_q <= DB'(PB'(target_q) * PB'(h2_q));
      lim_q  <= DB'(PB'(tol_q) * PB'(h2_q));
      hpos_q <= h2_q != '0;
      cb_q   <= ca_q;
    end
  end

  // stage c: deviation compare, output register
  corners_t co_q;
  logic pl_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      co_q <= cb_q;
      pl_q <= hpos_q && ((lhsa_q > lhsb_q ? lhsa_q - lhsb_q : lhsb_q - lhsa_q) <= lim_q);
    end
  end

  assign top_left_x_o     = co_q.tlx;
  assign top_left_y_o     = co_q.tly;
  assign top_right_x_o    = co_q.trx;
  assign top_right_y_o    = co_q.try_;
  assign bottom_right_x_o = co_q.brx;
  assign bottom_right_y_o = co_q.bry;
  assign bottom_left_x_o  = co_q.blx;
  assign bottom_left_y_o  = co_q.bly;
  assign plausible_o      = pl_q;

  // pipeline checks
  `QC_ASSERT(a_hold_valid, clk_i, rst_ni, out_stall_i |=> $stable(vld_q), "valid bits moved under stall")
  `QC_ASSERT(a_flow, clk_i, rst_ni, (!out_stall_i && in_valid_i) |=> vld_q[0], "accepted item lost")
  `QC_ASSERT(a_hold_out, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(co_q) && $stable(pl_q)), "stalled result changed")
endmodule
